// ===== rtl/core/alpha_bbox_crop_with_border_macros.svh =====
`ifndef ALPHA_BBOX_CROP_WITH_BORDER_MACROS_SVH
`define ALPHA_BBOX_CROP_WITH_BORDER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ABBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ABBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/abbc_pkg.sv =====
package abbc_pkg;

  localparam int unsigned DIM_W = 8;
  localparam int unsigned PIX_W = 32;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  localparam logic [DIM_W-1:0] RESET_IMAGE_WIDTH  = 8'd128;
  localparam logic [DIM_W-1:0] RESET_IMAGE_HEIGHT = 8'd128;
  localparam logic [7:0]       ALPHA_NONE         = 8'h00;
  localparam logic [PIX_W-1:0] BORDER_PIXEL       = 32'h0000_0000;

  typedef struct packed {
    logic             valid;
    logic             border;
    logic [DIM_W-1:0] out_width;
    logic [DIM_W-1:0] out_height;
    logic             last;
  } rd_req_t;

endpackage

// ===== rtl/core/abbc_intf.sv =====
interface abbc_in_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [abbc_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output kind, output pixel_in, input ready);
  modport sink   (input valid, input kind, input pixel_in, output ready);
endinterface

interface abbc_out_if;
  logic                       valid;
  logic                       ready;
  logic [abbc_pkg::PIX_W-1:0] pixel_out;
  logic [abbc_pkg::DIM_W-1:0] out_width;
  logic [abbc_pkg::DIM_W-1:0] out_height;
  logic                       last;

  modport source (output valid, output pixel_out, output out_width, output out_height,
                  output last, input ready);
  modport sink   (input valid, input pixel_out, input out_width, input out_height,
                  input last, output ready);
endinterface

interface abbc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [abbc_pkg::CFG_IDX_W-1:0] index;
  logic [abbc_pkg::DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/abbc_store.sv =====
module abbc_store #(
  parameter int unsigned DEPTH  = 16384,
  parameter int unsigned ADDR_W = 14
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic                       rd_en_i,
  input  logic [ADDR_W-1:0]          addr_i,
  input  logic [abbc_pkg::PIX_W-1:0] wdata_i,
  output logic [abbc_pkg::PIX_W-1:0] rdata_o
);
  import abbc_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/abbc_seq.sv =====
`include "alpha_bbox_crop_with_border_macros.svh"

module abbc_seq #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128,
  parameter int unsigned ADDR_W     = 14
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       acc_i,
  input  logic                       kind_i,
  input  logic [abbc_pkg::PIX_W-1:0] pixel_i,
  input  logic [abbc_pkg::DIM_W-1:0] image_width_i,
  input  logic [abbc_pkg::DIM_W-1:0] image_height_i,
  output logic                       mem_wr_o,
  output logic                       mem_rd_o,
  output logic [ADDR_W-1:0]          mem_addr_o,
  output abbc_pkg::rd_req_t          req_o
);
  import abbc_pkg::*;

  localparam logic [DIM_W-1:0] W_LIMIT = (MAX_WIDTH > 255) ? 8'd255 : DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] H_LIMIT = (MAX_HEIGHT > 255) ? 8'd255 : DIM_W'(MAX_HEIGHT);

  logic             started_q, full_q, any_q;
  logic [DIM_W-1:0] frame_w_q, frame_h_q;
  logic [DIM_W-1:0] ld_col_q, ld_row_q;
  logic [ADDR_W-1:0] ld_addr_q;
  logic [DIM_W-1:0] left_q, right_q, top_q, bottom_q;
  logic [DIM_W:0]   em_col_q, em_row_q;

  logic [DIM_W-1:0] clamp_w, clamp_h, cur_w, cur_h;
  logic             ld_en, rd_en, opaque, col_end, row_end;
  logic [DIM_W-1:0] l, r, t, b;
  logic [DIM_W:0]   ow, oh, row_sum, col_sum;
  logic             in_box, is_last;
  logic [2*DIM_W-1:0] prod;
  logic [2*DIM_W:0]   rd_addr;

  always_comb begin
    clamp_w = (image_width_i == '0) ? 8'd1 :
              (image_width_i > W_LIMIT) ? W_LIMIT : image_width_i;
    clamp_h = (image_height_i == '0) ? 8'd1 :
              (image_height_i > H_LIMIT) ? H_LIMIT : image_height_i;
    cur_w   = started_q ? frame_w_q : clamp_w;
    cur_h   = started_q ? frame_h_q : clamp_h;
    ld_en   = acc_i && !kind_i && !full_q;
    rd_en   = acc_i && kind_i && full_q;
    opaque  = pixel_i[31:24] != ALPHA_NONE;
    col_end = ld_col_q == cur_w - 8'd1;
    row_end = ld_row_q == cur_h - 8'd1;

    l  = any_q ? left_q   : '0;
    r  = any_q ? right_q  : '0;
    t  = any_q ? top_q    : '0;
    b  = any_q ? bottom_q : '0;
    ow = {1'b0, r} - {1'b0, l} + 9'd3;
    oh = {1'b0, b} - {1'b0, t} + 9'd3;
    in_box = (em_col_q != '0) && (em_col_q <= ow - 9'd2) &&
             (em_row_q != '0) && (em_row_q <= oh - 9'd2);
    is_last = (em_row_q == oh - 9'd1) && (em_col_q == ow - 9'd1);
    row_sum = {1'b0, t} + em_row_q - 9'd1;
    col_sum = {1'b0, l} + em_col_q - 9'd1;
    prod    = frame_w_q * row_sum[DIM_W-1:0];
    rd_addr = {1'b0, prod} + {{(DIM_W+1){1'b0}}, col_sum[DIM_W-1:0]};
  end

  assign mem_wr_o   = ld_en;
  assign mem_rd_o   = rd_en && in_box;
  assign mem_addr_o = ld_en ? ld_addr_q : ADDR_W'(rd_addr);

  always_comb begin
    req_o.valid      = rd_en;
    req_o.border     = !in_box;
    req_o.out_width  = ow[DIM_W-1:0];
    req_o.out_height = oh[DIM_W-1:0];
    req_o.last       = is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      full_q    <= 1'b0;
      any_q     <= 1'b0;
      frame_w_q <= '0;
      frame_h_q <= '0;
      ld_col_q  <= '0;
      ld_row_q  <= '0;
      ld_addr_q <= '0;
      left_q    <= '0;
      right_q   <= '0;
      top_q     <= '0;
      bottom_q  <= '0;
      em_col_q  <= '0;
      em_row_q  <= '0;
    end else if (ld_en) begin
      started_q <= 1'b1;
      frame_w_q <= cur_w;
      frame_h_q <= cur_h;
      ld_addr_q <= ld_addr_q + 1'b1;
      if (col_end) begin
        ld_col_q <= '0;
        ld_row_q <= ld_row_q + 8'd1;
        if (row_end) begin
          full_q <= 1'b1;
        end
      end else begin
        ld_col_q <= ld_col_q + 8'd1;
      end
      if (opaque) begin
        any_q <= 1'b1;
        if (!any_q) begin
          left_q   <= ld_col_q;
          right_q  <= ld_col_q;
          top_q    <= ld_row_q;
          bottom_q <= ld_row_q;
        end else begin
          if (ld_col_q < left_q)   left_q   <= ld_col_q;
          if (ld_col_q > right_q)  right_q  <= ld_col_q;
          if (ld_row_q < top_q)    top_q    <= ld_row_q;
          if (ld_row_q > bottom_q) bottom_q <= ld_row_q;
        end
      end
    end else if (rd_en) begin
      if (is_last) begin
        started_q <= 1'b0;
        full_q    <= 1'b0;
        any_q     <= 1'b0;
        frame_w_q <= '0;
        frame_h_q <= '0;
        ld_col_q  <= '0;
        ld_row_q  <= '0;
        ld_addr_q <= '0;
        left_q    <= '0;
        right_q   <= '0;
        top_q     <= '0;
        bottom_q  <= '0;
        em_col_q  <= '0;
        em_row_q  <= '0;
      end else if (em_col_q + 9'd1 >= ow) begin
        em_col_q <= '0;
        em_row_q <= em_row_q + 9'd1;
      end else begin
        em_col_q <= em_col_q + 9'd1;
      end
    end
  end

  `ABBC_ASSERT_NOW(a_emit_needs_full, req_o.valid, full_q && started_q, "read-out before frame complete")
  `ABBC_ASSERT_NEXT(a_last_clears, req_o.valid && req_o.last, !full_q && !started_q && !any_q, "frame state not cleared after last")
  `ABBC_ASSERT_NOW(a_emit_in_range, full_q, em_col_q < ow && em_row_q < oh, "read-out position outside output frame")

endmodule

// ===== rtl/core/alpha_bbox_crop_with_border.sv =====
// Alpha bounding-box crop. Load transactions (kind 0) write one ARGB pixel each into a
// single-port frame store in raster order, MAX_WIDTH*MAX_HEIGHT words, while the box of
// pixels with nonzero alpha is tracked; the frame size is taken from the registers at the
// first pixel of a frame. Once the frame is full, each read-out transaction (kind 1)
// returns the next pixel of the box framed by one zero pixel on every side, with the
// output size and a last flag; after the last pixel the block is ready for a new frame.
// Loads past the frame and read-outs before it is full are absorbed with no result. The
// block takes one transaction per cycle; a read-out's result is registered in the frame-store
// read stage and then in the output register before it leaves, and input stalls only
// while both the read stage and the output register hold results.
// The frame store needs no clearing after reset.
`include "alpha_bbox_crop_with_border_macros.svh"

module alpha_bbox_crop_with_border #(
  parameter int unsigned MAX_WIDTH  = 128,
  parameter int unsigned MAX_HEIGHT = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  abbc_in_if.sink    in_i,
  abbc_out_if.source out_o,
  abbc_cfg_if.sink   cfg_i
);
  import abbc_pkg::*;

  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DIM_W-1:0] image_width_q, image_height_q;
  logic             acc, out_free;
  logic             mem_wr, mem_rd;
  logic [ADDR_W-1:0] mem_addr;
  logic [PIX_W-1:0] mem_rdata;
  rd_req_t          req;
  rd_req_t          pend_q;
  logic             out_valid_q, out_last_q;
  logic [PIX_W-1:0] out_pixel_q;
  logic [DIM_W-1:0] out_width_q, out_height_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= RESET_IMAGE_WIDTH;
      image_height_q <= RESET_IMAGE_HEIGHT;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_IMAGE_WIDTH:  image_width_q  <= cfg_i.data;
        REG_IMAGE_HEIGHT: image_height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = !pend_q.valid || out_free;
  assign acc        = in_i.valid && in_i.ready;

  abbc_seq #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .ADDR_W    (ADDR_W)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .kind_i        (in_i.kind),
    .pixel_i       (in_i.pixel_in),
    .image_width_i (image_width_q),
    .image_height_i(image_height_q),
    .mem_wr_o      (mem_wr),
    .mem_rd_o      (mem_rd),
    .mem_addr_o    (mem_addr),
    .req_o         (req)
  );

  abbc_store #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk_i  (clk_i),
    .wr_en_i(mem_wr),
    .rd_en_i(mem_rd),
    .addr_i (mem_addr),
    .wdata_i(in_i.pixel_in),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pend_q.valid && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_i.ready) begin
        pend_q <= req;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q.valid && out_free) begin
      out_pixel_q  <= pend_q.border ? BORDER_PIXEL : mem_rdata;
      out_width_q  <= pend_q.out_width;
      out_height_q <= pend_q.out_height;
      out_last_q   <= pend_q.last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.pixel_out  = out_pixel_q;
  assign out_o.out_width  = out_width_q;
  assign out_o.out_height = out_height_q;
  assign out_o.last       = out_last_q;

  `ABBC_ASSERT_NOW(a_stall_only_when_full, !in_i.ready, pend_q.valid && out_valid_q && !out_o.ready, "input stalled without backpressure")
  `ABBC_ASSERT_NEXT(a_pend_holds, pend_q.valid && !out_free, pend_q.valid && $stable(pend_q.last) && $stable(pend_q.border), "pending read lost under stall")
  `ABBC_ASSERT_NEXT(a_pend_moves, pend_q.valid && out_free, out_valid_q, "pending read not moved to output")

endmodule
